@@ src/pcl_pkg.sv @@
// Shared types and constants for the polygon plane clipper.
package pcl_pkg;

   localparam int NORMAL_W   = 16;
   localparam int OFFSET_W   = 32;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [NORMAL_W-1:0] NORMAL_Z_RESET = 16'sd16384;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_NORMAL_X     = 2'd0,
      CSR_NORMAL_Y     = 2'd1,
      CSR_NORMAL_Z     = 2'd2,
      CSR_PLANE_OFFSET = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      OUT_CURRENT,
      OUT_FIRST,
      OUT_INTERSECT,
      OUT_EMPTY
   } out_sel_type;

   typedef struct packed {
      logic        capture;
      logic        dot_step;
      logic [1:0]  coord_idx;
      logic        dist_load;
      logic        edge_sel;
      logic        div_start;
      logic        div_step;
      logic        lerp_mul;
      logic        lerp_add;
      logic        out_load;
      out_sel_type out_sel;
      logic        out_end;
      logic        commit;
   } cmd_type;

   typedef struct packed {
      logic e1_cross;
      logic e1_emit;
      logic e2_cross;
      logic e2_emit;
      logic cur_last;
      logic seen_zero;
      logic out_free;
   } status_type;

endpackage

@@ src/polygon_plane_clipper.sv @@
// Top level of the single-plane polygon clipper.
//
// Vertices arrive on the req_ stream, one transaction per vertex, with tlast on
// the final vertex of each polygon. Clipped vertices leave on the rsp_ stream;
// tuser says whether the transaction carries a vertex, and tlast marks the final
// result of the polygon (an empty polygon gives one marker with tuser low).
// The plane normal and offset are written through the csr_ port while idle.
//
// Each vertex passes the dot product, distance, plan and commit states before
// the next is accepted, plus an emit state for each plain vertex it emits.
// Each intersection point adds COORD_FRAC_BITS ratio bits from a restoring
// divider, one per cycle, then one shared multiplier interpolates x, y and z
// in turn.
//
// Reset clears the plane to z = 1 through the origin and starts a new polygon.
// A stalled receiver holds the output register; the block still accepts the
// next vertex and works on it until it has a result to present.
module polygon_plane_clipper #(
   parameter int COORD_WIDTH      = 32,
   parameter int COORD_FRAC_BITS  = 16,
   parameter int NORMAL_FRAC_BITS = 14
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // vx, vy, vz from bit 0 up
   input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]  req_tdata,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // ox, oy, oz from bit 0 up
   output logic [((3*COORD_WIDTH+7)/8)*8-1:0]  rsp_tdata,
   // vertex_valid
   output logic                                rsp_tuser,
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [pcl_pkg::CSR_ADDR_W-1:0]      csr_index,
   input  logic [pcl_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int CW     = COORD_WIDTH;
   localparam int DATA_W = ((3*CW+7)/8)*8;

   pcl_pkg::cmd_type    cmd;
   pcl_pkg::status_type status;
   logic [CW-1:0]       ox, oy, oz;

   pcl_ctrl #(.FRAC(COORD_FRAC_BITS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .ready      (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pcl_dp #(
      .CW   (CW),
      .FRAC (COORD_FRAC_BITS),
      .NFB  (NORMAL_FRAC_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .in_x       (req_tdata[CW-1:0]),
      .in_y       (req_tdata[2*CW-1:CW]),
      .in_z       (req_tdata[3*CW-1:2*CW]),
      .in_last    (req_tlast),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .out_valid  (rsp_tvalid),
      .out_x      (ox),
      .out_y      (oy),
      .out_z      (oz),
      .out_vertex (rsp_tuser),
      .out_end    (rsp_tlast)
   );

   assign rsp_tdata = DATA_W'({oz, oy, ox});

   // An empty end marker always closes its polygon.
   a_empty_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast)
      else $error("empty marker without end of polygon");

   // An empty end marker carries zero coordinates.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> (rsp_tdata == '0))
      else $error("empty marker with nonzero coordinates");

   // The block is busy on the cycle after it takes a vertex.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after an accepted vertex");

endmodule

@@ src/pcl_ctrl.sv @@
// Sequencer for distance, edge classification, division and output of one vertex.
module pcl_ctrl #(
   parameter int FRAC = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 ready,
   input  pcl_pkg::status_type  status,
   output pcl_pkg::cmd_type     cmd
);

   localparam int CNT_W = $clog2(FRAC + 2);

   typedef enum logic [3:0] {
      ST_IDLE, ST_DOT, ST_DIST, ST_PLAN, ST_NEXT, ST_DIV, ST_DIVSTEP,
      ST_LMUL, ST_LADD, ST_EMIT, ST_COMMIT
   } state_type;

   state_type             state_ff, state_in;
   logic [1:0]            idx_ff, idx_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [3:0]            todo_ff, todo_in;
   logic                  empty_ff, empty_in;
   logic                  edge_ff, edge_in;
   pcl_pkg::out_sel_type  sel_ff, sel_in;
   logic                  end_ff, end_in;
   logic [3:0]            plan;

   assign ready = (state_ff == ST_IDLE);
   assign plan  = status.seen_zero ? 4'd0 :
                  {status.cur_last & status.e2_emit, status.cur_last & status.e2_cross,
                   status.e1_emit, status.e1_cross};

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      todo_in  = todo_ff;
      empty_in = empty_ff;
      edge_in  = edge_ff;
      sel_in   = sel_ff;
      end_in   = end_ff;
      cmd      = '0;
      cmd.coord_idx = idx_ff;
      cmd.edge_sel  = edge_ff;
      cmd.out_sel   = sel_ff;
      cmd.out_end   = end_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_tvalid;
            if (req_tvalid) begin
               state_in = ST_DOT;
               idx_in   = 2'd0;
            end
         end
         ST_DOT: begin
            cmd.dot_step = 1'b1;
            idx_in = idx_ff + 2'd1;
            if (idx_ff == 2'd2) begin
               state_in = ST_DIST;
            end
         end
         ST_DIST: begin
            cmd.dist_load = 1'b1;
            state_in = ST_PLAN;
         end
         ST_PLAN: begin
            todo_in  = plan;
            empty_in = status.cur_last && (plan == 4'd0);
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            idx_in = 2'd0;
            if (todo_ff[0]) begin
               todo_in  = {todo_ff[3:1], 1'b0};
               edge_in  = 1'b0;
               sel_in   = pcl_pkg::OUT_INTERSECT;
               state_in = ST_DIV;
            end else if (todo_ff[1]) begin
               todo_in  = {todo_ff[3:2], 2'b00};
               sel_in   = pcl_pkg::OUT_CURRENT;
               state_in = ST_EMIT;
            end else if (todo_ff[2]) begin
               todo_in  = {todo_ff[3], 3'b000};
               edge_in  = 1'b1;
               sel_in   = pcl_pkg::OUT_INTERSECT;
               state_in = ST_DIV;
            end else if (todo_ff[3]) begin
               todo_in  = 4'd0;
               sel_in   = pcl_pkg::OUT_FIRST;
               state_in = ST_EMIT;
            end else if (empty_ff) begin
               empty_in = 1'b0;
               sel_in   = pcl_pkg::OUT_EMPTY;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_COMMIT;
            end
            // The result that leaves nothing behind it closes the polygon.
            end_in = empty_ff || (status.cur_last && (todo_in == 4'd0));
         end
         ST_DIV: begin
            cmd.div_start = 1'b1;
            cnt_in   = '0;
            state_in = ST_DIVSTEP;
         end
         ST_DIVSTEP: begin
            if (cnt_ff == CNT_W'(FRAC)) begin
               state_in = ST_LMUL;
            end else begin
               cmd.div_step = 1'b1;
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_LMUL: begin
            cmd.lerp_mul = 1'b1;
            state_in = ST_LADD;
         end
         ST_LADD: begin
            cmd.lerp_add = 1'b1;
            idx_in = idx_ff + 2'd1;
            state_in = (idx_ff == 2'd2) ? ST_EMIT : ST_LMUL;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in = ST_NEXT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= 2'd0;
         cnt_ff   <= '0;
         todo_ff  <= 4'd0;
         empty_ff <= 1'b0;
         edge_ff  <= 1'b0;
         sel_ff   <= pcl_pkg::OUT_EMPTY;
         end_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
         todo_ff  <= todo_in;
         empty_ff <= empty_in;
         edge_ff  <= edge_in;
         sel_ff   <= sel_in;
         end_ff   <= end_in;
      end
   end

endmodule

@@ src/pcl_dp.sv @@
// Datapath: plane registers, vertex state, distance, divider, interpolation, output register.
module pcl_dp #(
   parameter int CW   = 32,
   parameter int FRAC = 16,
   parameter int NFB  = 14
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [pcl_pkg::CSR_ADDR_W-1:0]        csr_index,
   input  logic [pcl_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic [CW-1:0]                         in_x,
   input  logic [CW-1:0]                         in_y,
   input  logic [CW-1:0]                         in_z,
   input  logic                                  in_last,
   input  pcl_pkg::cmd_type                      cmd,
   output pcl_pkg::status_type                   status,
   input  logic                                  rsp_tready,
   output logic                                  out_valid,
   output logic [CW-1:0]                         out_x,
   output logic [CW-1:0]                         out_y,
   output logic [CW-1:0]                         out_z,
   output logic                                  out_vertex,
   output logic                                  out_end
);

   localparam int NW    = pcl_pkg::NORMAL_W;
   localparam int OW    = pcl_pkg::OFFSET_W;
   localparam int DPW   = CW + NW;
   localparam int ACC_W = CW + NW + 2;
   localparam int DW    = ((ACC_W - NFB > OW) ? ACC_W - NFB : OW) + 1;
   localparam int RW    = DW + 2;
   localparam int TW    = FRAC + 1;
   localparam int PW    = CW + TW + 2;
   localparam logic signed [PW:0] HALF =
      (FRAC > 0) ? ((PW+1)'(1) <<< ((FRAC > 0) ? FRAC - 1 : 0)) : '0;

   logic signed [NW-1:0]    nx_ff, ny_ff, nz_ff;
   logic signed [OW-1:0]    offset_ff;
   logic signed [CW-1:0]    cur_x_ff, cur_y_ff, cur_z_ff;
   logic                    cur_last_ff;
   logic signed [DW-1:0]    cur_d_ff, prev_d_ff, first_d_ff;
   logic signed [CW-1:0]    prev_x_ff, prev_y_ff, prev_z_ff;
   logic signed [CW-1:0]    first_x_ff, first_y_ff, first_z_ff;
   logic [1:0]              seen_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [RW-1:0]           rem_ff, rem_in;
   logic [DW:0]             den_ff;
   logic [TW-1:0]           q_ff;
   logic signed [PW-1:0]    lprod_ff;
   logic signed [CW-1:0]    ix_ff, iy_ff, iz_ff;
   logic                    valid_ff;

   logic signed [NW-1:0]    nsel;
   logic signed [CW-1:0]    csel;
   logic signed [DPW-1:0]   dprod;
   logic signed [ACC_W-1:0] dshift;
   logic signed [ACC_W:0]   dsum;
   logic signed [DW-1:0]    ds, de;
   logic [DW-1:0]           abs_s, abs_e;
   logic [RW-1:0]           r2;
   logic                    ge;
   logic signed [CW-1:0]    s_c, e_c;
   logic signed [CW:0]      diff;
   logic signed [PW:0]      lsum, lsh, lv;
   logic signed [CW-1:0]    lsat;
   logic                    fits;

   function automatic logic crosses(logic signed [DW-1:0] a, logic signed [DW-1:0] b);
      crosses = (a <= 0) ? (b > 0) : (b < 0);
   endfunction

   // Distance: one normal component times one coordinate per cycle.
   always_comb begin
      case (cmd.coord_idx)
         2'd0:    begin nsel = nx_ff; csel = cur_x_ff; end
         2'd1:    begin nsel = ny_ff; csel = cur_y_ff; end
         default: begin nsel = nz_ff; csel = cur_z_ff; end
      endcase
   end
   assign dprod  = DPW'(nsel) * DPW'(csel);
   assign acc_in = ((cmd.coord_idx == 2'd0) ? ACC_W'(0) : acc_ff) + ACC_W'(dprod);
   assign dshift = acc_ff >>> NFB;
   assign dsum   = (ACC_W+1)'(dshift) - (ACC_W+1)'(offset_ff);

   // Edge operands: start is the previous vertex or, on the closing edge, the current one.
   assign ds    = cmd.edge_sel ? cur_d_ff : prev_d_ff;
   assign de    = cmd.edge_sel ? first_d_ff : cur_d_ff;
   assign abs_s = ds[DW-1] ? DW'(-ds) : DW'(ds);
   assign abs_e = de[DW-1] ? DW'(-de) : DW'(de);
   assign r2    = {rem_ff[RW-2:0], 1'b0};
   assign ge    = (r2 >= RW'(den_ff));
   assign rem_in = ge ? (r2 - RW'(den_ff)) : r2;

   always_comb begin
      case (cmd.coord_idx)
         2'd0: begin
            s_c = cmd.edge_sel ? cur_x_ff : prev_x_ff;
            e_c = cmd.edge_sel ? first_x_ff : cur_x_ff;
         end
         2'd1: begin
            s_c = cmd.edge_sel ? cur_y_ff : prev_y_ff;
            e_c = cmd.edge_sel ? first_y_ff : cur_y_ff;
         end
         default: begin
            s_c = cmd.edge_sel ? cur_z_ff : prev_z_ff;
            e_c = cmd.edge_sel ? first_z_ff : cur_z_ff;
         end
      endcase
   end
   assign diff = (CW+1)'(e_c) - (CW+1)'(s_c);
   assign lsum = (PW+1)'(lprod_ff) + HALF;
   assign lsh  = lsum >>> FRAC;
   assign lv   = lsh + (PW+1)'(s_c);
   assign fits = (lv[PW:CW-1] == '0) || (lv[PW:CW-1] == '1);
   assign lsat = fits ? lv[CW-1:0] :
                 (lv[PW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}});

   assign status.e1_cross  = crosses(prev_d_ff, cur_d_ff);
   assign status.e1_emit   = (cur_d_ff <= 0);
   assign status.e2_cross  = crosses(cur_d_ff, first_d_ff);
   assign status.e2_emit   = (first_d_ff <= 0);
   assign status.cur_last  = cur_last_ff;
   assign status.seen_zero = (seen_ff == 2'd0);
   assign status.out_free  = !valid_ff || rsp_tready;
   assign out_valid        = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         nx_ff     <= '0;
         ny_ff     <= '0;
         nz_ff     <= pcl_pkg::NORMAL_Z_RESET;
         offset_ff <= '0;
      end else if (csr_we) begin
         case (pcl_pkg::csr_index_type'(csr_index))
            pcl_pkg::CSR_NORMAL_X:     nx_ff     <= csr_wdata[NW-1:0];
            pcl_pkg::CSR_NORMAL_Y:     ny_ff     <= csr_wdata[NW-1:0];
            pcl_pkg::CSR_NORMAL_Z:     nz_ff     <= csr_wdata[NW-1:0];
            pcl_pkg::CSR_PLANE_OFFSET: offset_ff <= csr_wdata[OW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff    <= 2'd0;
         prev_d_ff  <= '0;
         first_d_ff <= '0;
         prev_x_ff  <= '0;
         prev_y_ff  <= '0;
         prev_z_ff  <= '0;
         first_x_ff <= '0;
         first_y_ff <= '0;
         first_z_ff <= '0;
      end else if (cmd.commit) begin
         prev_x_ff <= cur_x_ff;
         prev_y_ff <= cur_y_ff;
         prev_z_ff <= cur_z_ff;
         prev_d_ff <= cur_d_ff;
         if (seen_ff == 2'd0) begin
            first_x_ff <= cur_x_ff;
            first_y_ff <= cur_y_ff;
            first_z_ff <= cur_z_ff;
            first_d_ff <= cur_d_ff;
         end
         seen_ff <= cur_last_ff ? 2'd0 : ((seen_ff == 2'd0) ? 2'd1 : 2'd2);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cur_x_ff    <= in_x;
         cur_y_ff    <= in_y;
         cur_z_ff    <= in_z;
         cur_last_ff <= in_last;
      end
      if (cmd.dot_step) begin
         acc_ff <= acc_in;
      end
      if (cmd.dist_load) begin
         cur_d_ff <= DW'(dsum);
      end
      if (cmd.div_start) begin
         rem_ff <= RW'(abs_s);
         den_ff <= (DW+1)'(abs_s) + (DW+1)'(abs_e);
         q_ff   <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         q_ff   <= TW'({q_ff, ge});
      end
      if (cmd.lerp_mul) begin
         lprod_ff <= PW'(diff) * PW'($signed({1'b0, q_ff}));
      end
      if (cmd.lerp_add) begin
         case (cmd.coord_idx)
            2'd0:    ix_ff <= lsat;
            2'd1:    iy_ff <= lsat;
            default: iz_ff <= lsat;
         endcase
      end
      if (cmd.out_load) begin
         out_end    <= cmd.out_end;
         out_vertex <= (cmd.out_sel != pcl_pkg::OUT_EMPTY);
         case (cmd.out_sel)
            pcl_pkg::OUT_CURRENT: begin
               out_x <= cur_x_ff; out_y <= cur_y_ff; out_z <= cur_z_ff;
            end
            pcl_pkg::OUT_FIRST: begin
               out_x <= first_x_ff; out_y <= first_y_ff; out_z <= first_z_ff;
            end
            pcl_pkg::OUT_INTERSECT: begin
               out_x <= ix_ff; out_y <= iy_ff; out_z <= iz_ff;
            end
            default: begin
               out_x <= '0; out_y <= '0; out_z <= '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

endmodule

@@ tb/polygon_plane_clipper_test.sv @@
// Self-checking testbench for the single-plane polygon clipper.
module polygon_plane_clipper_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  LATENCY_WAIT = 80;
   localparam int  STALL_LIMIT  = 5000;
   localparam longint COORD_MAX = 64'sd2147483647;
   localparam longint COORD_MIN = -64'sd2147483648;

   typedef struct {
      logic signed [31:0] x, y, z;
      logic               vld, eop;
   } clip_vertex_type;

   typedef struct {
      logic signed [31:0] x, y, z;
      logic               last;
      logic               fixed_empty;  // expected result is the empty end marker
   } stim_row_type;

   logic          clock = 0;
   logic          reset = 1;
   logic          req_tvalid = 0;
   logic          req_tready;
   logic [95:0]   req_tdata = '0;
   logic          req_tlast = 0;
   logic          rsp_tvalid;
   logic          rsp_tready = 0;
   logic [95:0]   rsp_tdata;
   logic          rsp_tuser;
   logic          rsp_tlast;
   logic          csr_we = 0;
   logic [pcl_pkg::CSR_ADDR_W-1:0] csr_index = '0;
   logic [pcl_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   polygon_plane_clipper dut (.*);

   always #6 clock = ~clock;

   // Plane and polygon state of the predictor.
   logic signed [15:0] plane_nx, plane_ny, plane_nz;
   logic signed [31:0] plane_off;
   longint             last_x, last_y, last_z, last_dist;
   longint             head_x, head_y, head_z, head_dist;
   int                 vertices_seen;

   clip_vertex_type expected_vertices[$];
   clip_vertex_type step_out[$];
   int           error_count = 0;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   int           quiet_cycles = 0;

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      error_count++;
   endtask

   function automatic longint saturate(input longint v);
      if (v > COORD_MAX) return COORD_MAX;
      if (v < COORD_MIN) return COORD_MIN;
      return v;
   endfunction

   function automatic longint plane_distance(input longint x, y, z);
      longint dot;
      dot = longint'(plane_nx) * x + longint'(plane_ny) * y + longint'(plane_nz) * z;
      return (dot >>> 14) - longint'(plane_off);
   endfunction

   function automatic longint interpolate(input longint s, e, t);
      longint p;
      p = (e - s) * t;
      return saturate(s + ((p + 32768) >>> 16));
   endfunction

   function automatic void add_vertex(input longint x, y, z, input logic vld);
      clip_vertex_type v;
      v.x = 32'(saturate(x));
      v.y = 32'(saturate(y));
      v.z = 32'(saturate(z));
      v.vld = vld;
      v.eop = 0;
      step_out.insert(step_out.size(), v);
   endfunction

   function automatic void clip_edge(input longint sx, sy, sz, ds, ex, ey, ez, de);
      longint as, ae, t;
      if ((ds <= 0) ? (de > 0) : (de < 0)) begin
         as = ds < 0 ? -ds : ds;
         ae = de < 0 ? -de : de;
         t = (as << 16) / (as + ae);
         add_vertex(interpolate(sx, ex, t), interpolate(sy, ey, t),
                    interpolate(sz, ez, t), 1'b1);
      end
      if (de <= 0) add_vertex(ex, ey, ez, 1'b1);
   endfunction

   // Advances the clipper state by one vertex and returns the results it causes.
   function automatic void clip_vertex(input longint x, y, z, input logic last);
      longint d;
      step_out.delete();
      d = plane_distance(x, y, z);
      if (vertices_seen == 0) begin
         head_x = x; head_y = y; head_z = z; head_dist = d;
         vertices_seen = 1;
      end else begin
         clip_edge(last_x, last_y, last_z, last_dist, x, y, z, d);
         if (last) clip_edge(x, y, z, d, head_x, head_y, head_z, head_dist);
         vertices_seen = 2;
      end
      last_x = x; last_y = y; last_z = z; last_dist = d;
      if (last) begin
         if (step_out.size() == 0) add_vertex(0, 0, 0, 1'b0);
         step_out[step_out.size()-1].eop = 1;
         vertices_seen = 0;
      end
   endfunction

   // Result side: random stalls and the scoreboard.
   always @(posedge clock) begin
      clip_vertex_type exp_v;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_vertices.size() == 0) begin
               report_mismatch("result transaction with nothing expected");
            end else begin
               exp_v = expected_vertices.pop_front();
               if (rsp_tdata[31:0] !== exp_v.x)
                  report_mismatch($sformatf("ox %h, expected %h", rsp_tdata[31:0], exp_v.x));
               if (rsp_tdata[63:32] !== exp_v.y)
                  report_mismatch($sformatf("oy %h, expected %h", rsp_tdata[63:32], exp_v.y));
               if (rsp_tdata[95:64] !== exp_v.z)
                  report_mismatch($sformatf("oz %h, expected %h", rsp_tdata[95:64], exp_v.z));
               if (rsp_tuser !== exp_v.vld)
                  report_mismatch($sformatf("vertex_valid %b, expected %b", rsp_tuser, exp_v.vld));
               if (rsp_tlast !== exp_v.eop)
                  report_mismatch($sformatf("end_of_polygon %b, expected %b",
                                            rsp_tlast, exp_v.eop));
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog on cycles in which no transaction moves on either side.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("polygon_plane_clipper verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_vertex(input logic signed [31:0] x, y, z, input logic last);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {z, y, x};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (expected_vertices.size() != 0) @(posedge clock);
      repeat (LATENCY_WAIT) @(posedge clock);
   endtask

   task automatic write_plane(input logic signed [15:0] nx, ny, nz,
                              input logic signed [31:0] off);
      drain();
      csr_we <= 1;
      csr_index <= pcl_pkg::CSR_NORMAL_X;     csr_wdata <= {{16{nx[15]}}, nx};
      @(posedge clock);
      csr_index <= pcl_pkg::CSR_NORMAL_Y;     csr_wdata <= {{16{ny[15]}}, ny};
      @(posedge clock);
      csr_index <= pcl_pkg::CSR_NORMAL_Z;     csr_wdata <= {{16{nz[15]}}, nz};
      @(posedge clock);
      csr_index <= pcl_pkg::CSR_PLANE_OFFSET; csr_wdata <= off;
      @(posedge clock);
      csr_we <= 0;
      plane_nx = nx; plane_ny = ny; plane_nz = nz; plane_off = off;
   endtask

   function automatic logic signed [31:0] pick_coord();
      case ($urandom_range(0, 5))
         0:       return $urandom;
         1:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         2:       return 0;
         default: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      endcase
   endfunction

   task automatic send_checked(input logic signed [31:0] x, y, z, input logic last,
                               input logic fixed_empty);
      clip_vertex_type marker;
      send_vertex(x, y, z, last);
      clip_vertex(x, y, z, last);
      if (fixed_empty) begin
         marker.x = 0; marker.y = 0; marker.z = 0; marker.vld = 0; marker.eop = 1;
         expected_vertices.insert(expected_vertices.size(), marker);
      end else begin
         foreach (step_out[i]) expected_vertices.insert(expected_vertices.size(), step_out[i]);
      end
   endtask

   // Reset plane is z = 0 with the clipped side above, so the distance is just z.
   localparam int ONE = 65536;
   stim_row_type directed_rows[] = '{
      '{0, 0, 0, 1, 1},                                     // one-vertex polygon
      '{0, 0, -ONE, 0, 0}, '{ONE, 0, -ONE, 0, 0}, '{0, ONE, -ONE, 1, 0},
      '{0, 0, -ONE, 0, 0}, '{0, 0, ONE, 0, 0}, '{ONE, 0, ONE, 1, 0},
      '{5, 7, 0, 0, 0}, '{ONE, ONE, 3 * ONE, 1, 0},         // start on the plane
      '{3, 4, ONE, 0, 0}, '{ONE, 2, 0, 1, 0},               // outside into the plane
      '{1, 1, ONE, 0, 0}, '{2, 2, ONE, 1, 1},               // all outside
      '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0, 0},
      '{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 0, 0},
      '{32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 1, 0},
      '{32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0},
      '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0, 0},
      '{-ONE, ONE, -5, 0, 0}, '{ONE, -ONE, 9, 1, 0}
   };

   initial begin
      int n_sides;
      int phase;
      plane_nx = 0; plane_ny = 0; plane_nz = pcl_pkg::NORMAL_Z_RESET; plane_off = 0;
      last_x = 0; last_y = 0; last_z = 0; last_dist = 0;
      head_x = 0; head_y = 0; head_z = 0; head_dist = 0;
      vertices_seen = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_checked(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
                      directed_rows[i].last, directed_rows[i].fixed_empty);

      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: write_plane(16'sd16384, 16'sd0, 16'sd0, 32'sd0);
            1: write_plane(-16'sd32768, 16'sd32767, -16'sd32768, 32'sh80000000);
            2: write_plane(16'sd32767, 16'sd32767, 16'sd32767, 32'sh7fffffff);
            3: write_plane(16'sd0, -16'sd16384, 16'sd8192, 32'sd196608);
            default: write_plane(16'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 255)),
                                 16'($urandom), 16'($urandom),
                                 $urandom_range(0, 1) ? $urandom : 0);
         endcase
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
            default: begin send_idle_pct = 7; recv_stall_pct = 7; end
         endcase
         for (int sent = 0; sent < 25; ) begin
            n_sides = $urandom_range(0, 9) == 0 ? 1 : $urandom_range(2, 6);
            for (int k = 0; k < n_sides; k++)
               send_checked(pick_coord(), pick_coord(), pick_coord(),
                            k == n_sides - 1, 1'b0);
            sent += n_sides;
         end
      end

      drain();
      if (error_count == 0) begin
         $display("polygon_plane_clipper verification clean");
      end else begin
         $display("polygon_plane_clipper verification failed");
      end
      $finish;
   end
endmodule
